@@ sv/prtrr_pkg.sv @@
// Package for the task table scheduler: table sizes, command, state and
// status codes, controller phases and the controller/datapath structs.
// Used by every module of the block; depends on nothing.
package prtrr_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int PID_W   = 16;
  localparam int TICK_W  = 32;
  localparam int SLICE_RESET = 10;
  localparam logic [PID_W-1:0] PID_PROTECTED = 16'd1;
  localparam logic [PID_W-1:0] PID_FIRST     = 16'd1;
  localparam logic [PID_W-1:0] PID_LAST      = 16'hFFFF;
  localparam logic [15:0]      TIME_MAX      = 16'hFFFF;

  typedef enum logic [3:0] {
    CMD_CREATE    = 4'd0,
    CMD_DESTROY   = 4'd1,
    CMD_KILL      = 4'd2,
    CMD_TERMINATE = 4'd3,
    CMD_TICK      = 4'd4,
    CMD_YIELD     = 4'd5,
    CMD_SCHEDULE  = 4'd6,
    CMD_SET_STATE = 4'd7,
    CMD_QUERY     = 4'd8
  } cmd_e;

  localparam logic [2:0] TS_CREATED    = 3'd0;
  localparam logic [2:0] TS_READY      = 3'd1;
  localparam logic [2:0] TS_RUNNING    = 3'd2;
  localparam logic [2:0] TS_WAITING    = 3'd3;
  localparam logic [2:0] TS_TERMINATED = 3'd4;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_NO_SLOT   = 2'd2;
  localparam logic [1:0] STS_REFUSED   = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIND,
    PH_EXEC,
    PH_CHARGE,
    PH_SEARCH,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic capture;
    logic find;
    logic exec;
    logic charge;
    logic search;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic sched_req;
  } sts_t;

endpackage

@@ sv/prtrr_ctrl.sv @@
// Controller for the task table scheduler: sequences find, execute,
// charge, search and finish phases. Depends on prtrr_pkg.
module prtrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  prtrr_pkg::sts_t   sts,
  output prtrr_pkg::ctl_t   ctl,
  output logic              busy,
  output logic              done
);
  import prtrr_pkg::*;

  phase_t state_r, state_nxt;
  logic   done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    ctl       = '0;
    unique case (state_r)
      PH_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_nxt   = PH_FIND;
        end
      end
      PH_FIND: begin
        ctl.find  = 1'b1;
        state_nxt = PH_EXEC;
      end
      PH_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = sts.sched_req ? PH_CHARGE : PH_DONE;
      end
      PH_CHARGE: begin
        ctl.charge = 1'b1;
        state_nxt  = PH_SEARCH;
      end
      PH_SEARCH: begin
        ctl.search = 1'b1;
        state_nxt  = PH_DONE;
      end
      PH_DONE: begin
        ctl.finish = 1'b1;
        done_nxt   = 1'b1;
        state_nxt  = PH_IDLE;
      end
      default: state_nxt = PH_IDLE;
    endcase
  end

  assign busy = (state_r != PH_IDLE);
  assign done = done_r;

  a_accept_find: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == PH_FIND))
    else $error("accepted command did not enter find phase");
  a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == PH_DONE))
    else $error("result strobe without finish phase");

endmodule

@@ sv/prtrr_datapath.sv @@
// Datapath for the task table scheduler: slot table, id lookup, free slot
// search, charge logic, rotated ready search and result registers.
// Depends on prtrr_pkg; driven by prtrr_ctrl.
module prtrr_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prtrr_pkg::ctl_t             ctl,
  output prtrr_pkg::sts_t             sts,
  input  logic [15:0]                 slice_len,
  input  logic [3:0]                  command,
  input  logic [prtrr_pkg::PID_W-1:0] target_pid,
  input  logic [2:0]                  new_priority,
  input  logic [2:0]                  new_state,
  input  logic signed [31:0]          exit_value,
  output logic [1:0]                  status,
  output logic [prtrr_pkg::PID_W-1:0] result_pid,
  output logic [prtrr_pkg::PID_W-1:0] current_pid,
  output logic [2:0]                  entry_state,
  output logic [2:0]                  entry_priority,
  output logic [15:0]                 entry_time_used,
  output logic [31:0]                 entry_created_at,
  output logic [prtrr_pkg::PID_W-1:0] entry_parent_pid,
  output logic signed [31:0]          entry_exit_value,
  output logic [prtrr_pkg::CNT_W-1:0] live_count
);
  import prtrr_pkg::*;

  logic [SLOTS-1:0] used_r;
  logic [PID_W-1:0] pid_r  [SLOTS];
  logic [2:0]       st_r   [SLOTS];
  logic [2:0]       prio_r [SLOTS];
  logic [15:0]      tu_r   [SLOTS];
  logic [31:0]      crt_r  [SLOTS];
  logic [PID_W-1:0] par_r  [SLOTS];
  logic [31:0]      exit_r [SLOTS];

  logic [SLOT_W-1:0] cur_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PID_W-1:0]  nid_r;
  logic [TICK_W-1:0] tick_r;

  logic [3:0]        cmd_q_r;
  logic [PID_W-1:0]  tpid_q_r;
  logic [2:0]        prio_q_r;
  logic [2:0]        nst_q_r;
  logic [31:0]       xv_q_r;

  logic              hit_r, free_r;
  logic [SLOT_W-1:0] hit_idx_r, free_idx_r;

  logic [1:0]        o_status_r;
  logic [PID_W-1:0]  o_rpid_r, o_cur_pid_r, o_par_r;
  logic [2:0]        o_st_r, o_prio_r;
  logic [15:0]       o_tu_r;
  logic [31:0]       o_crt_r, o_exit_r;
  logic [CNT_W-1:0]  o_live_r;

  // lookup and free slot, lowest index wins
  logic              hit_c, free_c;
  logic [SLOT_W-1:0] hit_idx_c, free_idx_c;
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && (pid_r[i] == tpid_q_r)) begin
        hit_c     = 1'b1;
        hit_idx_c = SLOT_W'(i);
      end
      if (!used_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = SLOT_W'(i);
      end
    end
  end

  // one read port on time used: query slot during execute, else current slot
  logic [SLOT_W-1:0] tu_idx;
  logic [15:0]       tu_rd, tu_sat;
  logic              cur_run, demote;
  assign tu_idx  = (ctl.exec && (cmd_q_r == CMD_QUERY)) ? hit_idx_r : cur_r;
  assign tu_rd   = tu_r[tu_idx];
  assign tu_sat  = (tu_rd == TIME_MAX) ? TIME_MAX : tu_rd + 16'd1;
  assign demote  = (tu_sat >= slice_len);
  assign cur_run = used_r[cur_r] && (st_r[cur_r] == TS_RUNNING);

  always_comb begin
    sts.sched_req = 1'b0;
    case (cmd_q_r)
      CMD_TERMINATE, CMD_YIELD: sts.sched_req = used_r[cur_r];
      CMD_SCHEDULE:             sts.sched_req = 1'b1;
      CMD_TICK:                 sts.sched_req = cur_run && demote;
      default:                  sts.sched_req = 1'b0;
    endcase
  end

  // rotated ready search starting after the current slot
  logic              rdy_c;
  logic [SLOT_W-1:0] rdy_idx_c;
  logic [SLOT_W:0]   rot;
  always_comb begin
    rdy_c     = 1'b0;
    rdy_idx_c = '0;
    rot       = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      rot = {1'b0, cur_r} + (SLOT_W+1)'(i + 1);
      if (rot >= (SLOT_W+1)'(SLOTS)) rot = rot - (SLOT_W+1)'(SLOTS);
      if (used_r[rot[SLOT_W-1:0]] && (st_r[rot[SLOT_W-1:0]] == TS_READY)) begin
        rdy_c     = 1'b1;
        rdy_idx_c = rot[SLOT_W-1:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cur_r  <= '0;
      cnt_r  <= '0;
      nid_r  <= PID_FIRST;
      tick_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        pid_r[i] <= '0;
        st_r[i]  <= TS_CREATED;
      end
    end else if (ctl.exec) begin
      case (cmd_q_r)
        CMD_CREATE: begin
          if (free_r) begin
            used_r[free_idx_r] <= 1'b1;
            pid_r[free_idx_r]  <= nid_r;
            st_r[free_idx_r]   <= TS_READY;
            cnt_r              <= cnt_r + CNT_W'(1);
            nid_r              <= (nid_r == PID_LAST) ? PID_FIRST : nid_r + PID_FIRST;
          end
        end
        CMD_DESTROY: begin
          if (hit_r) begin
            if (st_r[hit_idx_r] == TS_RUNNING) begin
              st_r[hit_idx_r] <= TS_TERMINATED;
            end else begin
              used_r[hit_idx_r] <= 1'b0;
              cnt_r             <= cnt_r - CNT_W'(1);
            end
          end
        end
        CMD_KILL: begin
          if (hit_r && (pid_r[hit_idx_r] != PID_PROTECTED)) begin
            st_r[hit_idx_r]   <= TS_TERMINATED;
            used_r[hit_idx_r] <= 1'b0;
            cnt_r             <= cnt_r - CNT_W'(1);
          end
        end
        CMD_TERMINATE: if (used_r[cur_r]) st_r[cur_r] <= TS_TERMINATED;
        CMD_TICK: begin
          tick_r <= tick_r + TICK_W'(1);
          if (cur_run && demote) st_r[cur_r] <= TS_READY;
        end
        CMD_YIELD: if (used_r[cur_r]) st_r[cur_r] <= TS_READY;
        CMD_SET_STATE: begin
          if (hit_r && (nst_q_r <= TS_TERMINATED)) st_r[hit_idx_r] <= nst_q_r;
        end
        default: ;
      endcase
    end else if (ctl.charge) begin
      if (cur_run && demote) st_r[cur_r] <= TS_READY;
    end else if (ctl.search) begin
      if (rdy_c) begin
        cur_r           <= rdy_idx_c;
        st_r[rdy_idx_c] <= TS_RUNNING;
      end
    end
  end

  // payload fields of the table, input capture and lookup results
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q_r  <= command;
      tpid_q_r <= target_pid;
      prio_q_r <= new_priority;
      nst_q_r  <= new_state;
      xv_q_r   <= exit_value;
    end
    if (ctl.find) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      free_r     <= free_c;
      free_idx_r <= free_idx_c;
    end
    if (ctl.exec) begin
      case (cmd_q_r)
        CMD_CREATE: begin
          if (free_r) begin
            prio_r[free_idx_r] <= prio_q_r;
            tu_r[free_idx_r]   <= '0;
            crt_r[free_idx_r]  <= tick_r;
            par_r[free_idx_r]  <= used_r[cur_r] ? pid_r[cur_r] : '0;
            exit_r[free_idx_r] <= '0;
          end
        end
        CMD_TERMINATE: if (used_r[cur_r]) exit_r[cur_r] <= xv_q_r;
        CMD_TICK: if (cur_run) tu_r[cur_r] <= demote ? 16'd0 : tu_sat;
        CMD_YIELD: if (used_r[cur_r]) tu_r[cur_r] <= slice_len;
        default: ;
      endcase
    end
    if (ctl.charge && cur_run) tu_r[cur_r] <= demote ? 16'd0 : tu_sat;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      o_status_r <= STS_OK;
      o_rpid_r   <= tpid_q_r;
      o_st_r     <= '0;
      o_prio_r   <= '0;
      o_tu_r     <= '0;
      o_crt_r    <= '0;
      o_par_r    <= '0;
      o_exit_r   <= '0;
      case (cmd_q_r)
        CMD_CREATE: begin
          o_rpid_r   <= free_r ? nid_r : '0;
          o_status_r <= free_r ? STS_OK : STS_NO_SLOT;
        end
        CMD_DESTROY, CMD_SET_STATE: if (!hit_r) o_status_r <= STS_NOT_FOUND;
        CMD_KILL: begin
          if (!hit_r) o_status_r <= STS_NOT_FOUND;
          else if (pid_r[hit_idx_r] == PID_PROTECTED) o_status_r <= STS_REFUSED;
        end
        CMD_TERMINATE, CMD_YIELD: if (!used_r[cur_r]) o_status_r <= STS_NOT_FOUND;
        CMD_QUERY: begin
          if (!hit_r) begin
            o_status_r <= STS_NOT_FOUND;
          end else begin
            o_st_r   <= st_r[hit_idx_r];
            o_prio_r <= prio_r[hit_idx_r];
            o_tu_r   <= tu_rd;
            o_crt_r  <= crt_r[hit_idx_r];
            o_par_r  <= par_r[hit_idx_r];
            o_exit_r <= exit_r[hit_idx_r];
          end
        end
        default: ;
      endcase
    end
    if (ctl.finish) begin
      o_cur_pid_r <= used_r[cur_r] ? pid_r[cur_r] : '0;
      o_live_r    <= cnt_r;
    end
  end

  assign status           = o_status_r;
  assign result_pid       = o_rpid_r;
  assign current_pid      = o_cur_pid_r;
  assign entry_state      = o_st_r;
  assign entry_priority   = o_prio_r;
  assign entry_time_used  = o_tu_r;
  assign entry_created_at = o_crt_r;
  assign entry_parent_pid = o_par_r;
  assign entry_exit_value = o_exit_r;
  assign live_count       = o_live_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(used_r)))
    else $error("live count out of step with used slots");
  a_next_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    nid_r != '0)
    else $error("next id reached zero");

endmodule

@@ sv/process_table_round_robin_scheduler_unit.sv @@
// Top level of the task table round-robin scheduler: APB slice register,
// controller and datapath. Depends on prtrr_pkg, prtrr_ctrl, prtrr_datapath.
//
//  channel   ports                         transfer when
//  --------  ----------------------------  ------------------------------------
//  command   start, busy, in_*             start high and busy low
//  result    out_valid, out_*              out_valid high (one cycle, no stall)
//  config    psel, penable, pwrite, paddr  psel & penable & pwrite & pready
//
// A command passes the find, execute and finish phases to its result strobe;
// one that runs the scheduler adds charge then rotated ready search (16 slots).
// busy stays high from the transfer until the result strobe cycle, in which
// the next command may already be taken. Reset clears the used, id and
// state table and the control counters directly; no clearing pass.
// The result receiver cannot stall: each result is shown for one cycle.
module process_table_round_robin_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_command,
  input  logic [prtrr_pkg::PID_W-1:0] in_target_pid,
  input  logic [2:0]                  in_new_priority,
  input  logic [2:0]                  in_new_state,
  input  logic signed [31:0]          in_exit_value,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [prtrr_pkg::PID_W-1:0] out_result_pid,
  output logic [prtrr_pkg::PID_W-1:0] out_current_pid,
  output logic [2:0]                  out_entry_state,
  output logic [2:0]                  out_entry_priority,
  output logic [15:0]                 out_entry_time_used,
  output logic [31:0]                 out_entry_created_at,
  output logic [prtrr_pkg::PID_W-1:0] out_entry_parent_pid,
  output logic signed [31:0]          out_entry_exit_value,
  output logic [prtrr_pkg::CNT_W-1:0] out_live_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import prtrr_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [15:0] slice_r;
  logic        cmd_start;

  assign pready = 1'b1;

  // slice length register wherever paddr[2] is low (words 0 to 3); words 4 to 7 read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= 16'(SLICE_RESET);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      slice_r <= pwdata[15:0];
    end
  end

  assign prdata    = paddr[2] ? 32'd0 : {16'd0, slice_r};
  // the controller only looks at start while idle
  assign cmd_start = start;

  prtrr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd_start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (out_valid)
  );

  prtrr_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .slice_len        (slice_r),
    .command          (in_command),
    .target_pid       (in_target_pid),
    .new_priority     (in_new_priority),
    .new_state        (in_new_state),
    .exit_value       (in_exit_value),
    .status           (out_status),
    .result_pid       (out_result_pid),
    .current_pid      (out_current_pid),
    .entry_state      (out_entry_state),
    .entry_priority   (out_entry_priority),
    .entry_time_used  (out_entry_time_used),
    .entry_created_at (out_entry_created_at),
    .entry_parent_pid (out_entry_parent_pid),
    .entry_exit_value (out_entry_exit_value),
    .live_count       (out_live_count)
  );

endmodule

@@ test/process_table_round_robin_scheduler_unit_tb.sv @@
// Testbench for the task table round-robin scheduler: command driver, result
// monitor and a behavioral table predictor, with slice register writes over APB.
// Depends on prtrr_pkg and process_table_round_robin_scheduler_unit.
`timescale 1ns / 100ps

module process_table_round_robin_scheduler_unit_tb;
  import prtrr_pkg::*;

  typedef struct packed {
    logic [3:0]         command;
    logic [15:0]        target_pid;
    logic [2:0]         new_priority;
    logic [2:0]         new_state;
    logic signed [31:0] exit_value;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        result_pid;
    logic [15:0]        current_pid;
    logic [2:0]         entry_state;
    logic [2:0]         entry_priority;
    logic [15:0]        entry_time_used;
    logic [31:0]        entry_created_at;
    logic [15:0]        entry_parent_pid;
    logic signed [31:0] entry_exit_value;
    logic [4:0]         live_count;
  } answer_t;

  localparam logic [2:0] ADDR_SLICE = 3'd0;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n, start, busy, out_valid, psel, penable, pwrite, pready;
  logic [3:0] in_command;
  logic [15:0] in_target_pid, out_result_pid, out_current_pid, out_entry_parent_pid;
  logic [2:0] in_new_priority, in_new_state, out_entry_state, out_entry_priority, paddr;
  logic signed [31:0] in_exit_value, out_entry_exit_value;
  logic [1:0] out_status;
  logic [15:0] out_entry_time_used;
  logic [31:0] out_entry_created_at, pwdata, prdata;
  logic [CNT_W-1:0] out_live_count;

  process_table_round_robin_scheduler_unit uut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Predictor copy of the task table
  logic        tbl_used [SLOTS];
  logic [15:0] tbl_pid [SLOTS];
  logic [2:0]  tbl_state [SLOTS];
  logic [2:0]  tbl_prio [SLOTS];
  logic [15:0] tbl_time [SLOTS];
  logic [31:0] tbl_born [SLOTS];
  logic [15:0] tbl_parent [SLOTS];
  logic [31:0] tbl_exit [SLOTS];
  int unsigned cur_slot, live;
  logic [15:0] id_next, slice_len;
  logic [31:0] ticks;

  cmd_item_t pending_cmds[$];
  answer_t   awaited[$];
  int mismatches;
  int unsigned cycles;

  function automatic int lookup(logic [15:0] pid);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_used[i] && tbl_pid[i] == pid) return i;
    return -1;
  endfunction

  task automatic charge_slot(int s);
    if (tbl_time[s] != 16'hFFFF) tbl_time[s]++;
    if (tbl_time[s] >= slice_len) begin
      tbl_state[s] = TS_READY;
      tbl_time[s] = '0;
    end
  endtask

  task automatic rotate;
    int c, idx;
    c = cur_slot;
    if (live == 0) return;
    if (tbl_used[c] && tbl_state[c] == TS_RUNNING) charge_slot(c);
    for (int i = 0; i < SLOTS; i++) begin
      idx = (c + 1 + i) % SLOTS;
      if (tbl_used[idx] && tbl_state[idx] == TS_READY) begin
        cur_slot = idx;
        tbl_state[idx] = TS_RUNNING;
        return;
      end
    end
  endtask

  task automatic predict_answer(cmd_item_t c);
    answer_t a;
    int s, cur;
    a = '0;
    a.result_pid = c.target_pid;
    cur = cur_slot;
    s = -1;
    case (c.command)
      CMD_CREATE: begin
        a.result_pid = '0;
        for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_used[i]) s = i;
        if (s < 0) a.status = STS_NO_SLOT;
        else begin
          a.result_pid = id_next;
          id_next = (id_next == PID_LAST) ? PID_FIRST : id_next + 16'd1;
          tbl_pid[s] = a.result_pid;
          tbl_state[s] = TS_READY;
          tbl_prio[s] = c.new_priority;
          tbl_time[s] = '0;
          tbl_born[s] = ticks;
          tbl_parent[s] = tbl_used[cur] ? tbl_pid[cur] : 16'd0;
          tbl_exit[s] = '0;
          tbl_used[s] = 1'b1;
          live++;
        end
      end
      CMD_DESTROY: begin
        s = lookup(c.target_pid);
        if (s < 0) a.status = STS_NOT_FOUND;
        else if (tbl_state[s] == TS_RUNNING) tbl_state[s] = TS_TERMINATED;
        else begin
          tbl_used[s] = 1'b0;
          live--;
        end
      end
      CMD_KILL: begin
        s = lookup(c.target_pid);
        if (s < 0) a.status = STS_NOT_FOUND;
        else if (tbl_pid[s] == PID_PROTECTED) a.status = STS_REFUSED;
        else begin
          tbl_state[s] = TS_TERMINATED;
          tbl_used[s] = 1'b0;
          live--;
        end
      end
      CMD_TERMINATE: begin
        if (!tbl_used[cur]) a.status = STS_NOT_FOUND;
        else begin
          tbl_exit[cur] = c.exit_value;
          tbl_state[cur] = TS_TERMINATED;
          rotate();
        end
      end
      CMD_TICK: begin
        ticks++;
        if (tbl_used[cur] && tbl_state[cur] == TS_RUNNING) begin
          charge_slot(cur);
          if (tbl_state[cur] == TS_READY) rotate();
        end
      end
      CMD_YIELD: begin
        if (!tbl_used[cur]) a.status = STS_NOT_FOUND;
        else begin
          tbl_state[cur] = TS_READY;
          tbl_time[cur] = slice_len;
          rotate();
        end
      end
      CMD_SCHEDULE: rotate();
      CMD_SET_STATE: begin
        s = lookup(c.target_pid);
        if (s < 0) a.status = STS_NOT_FOUND;
        else if (c.new_state <= TS_TERMINATED) tbl_state[s] = c.new_state;
      end
      CMD_QUERY: begin
        s = lookup(c.target_pid);
        if (s < 0) a.status = STS_NOT_FOUND;
        else begin
          a.entry_state = tbl_state[s];
          a.entry_priority = tbl_prio[s];
          a.entry_time_used = tbl_time[s];
          a.entry_created_at = tbl_born[s];
          a.entry_parent_pid = tbl_parent[s];
          a.entry_exit_value = tbl_exit[s];
        end
      end
      default: ;
    endcase
    a.current_pid = tbl_used[cur_slot] ? tbl_pid[cur_slot] : 16'd0;
    a.live_count = live[4:0];
    awaited.push_back(a);
  endtask

  // Driver: present the next queued command; hold start while busy
  int idle_pct;
  bit hold_off, cfg_owned;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the current command until it transfers
    end else begin
      if (start) predict_answer({in_command, in_target_pid, in_new_priority,
                                 in_new_state, in_exit_value});
      if (!hold_off && !cfg_owned && pending_cmds.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        cmd_item_t c;
        c = pending_cmds.pop_front();
        start <= 1'b1;
        in_command <= c.command;
        in_target_pid <= c.target_pid;
        in_new_priority <= c.new_priority;
        in_new_state <= c.new_state;
        in_exit_value <= c.exit_value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare every strobed result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      answer_t got, want;
      got = {out_status, out_result_pid, out_current_pid, out_entry_state,
             out_entry_priority, out_entry_time_used, out_entry_created_at,
             out_entry_parent_pid, out_entry_exit_value, out_live_count[4:0]};
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("process_table_round_robin_scheduler_unit verification failed");
      $finish;
    end
  end

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    int r;
    c.exit_value = $urandom;
    c.new_priority = 3'($urandom_range(7));
    c.new_state = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    r = $urandom_range(99);
    // weight toward commands that exercise the scheduler
    if (r < 18) c.command = CMD_CREATE;
    else if (r < 26) c.command = CMD_DESTROY;
    else if (r < 32) c.command = CMD_KILL;
    else if (r < 37) c.command = CMD_TERMINATE;
    else if (r < 60) c.command = CMD_TICK;
    else if (r < 66) c.command = CMD_YIELD;
    else if (r < 74) c.command = CMD_SCHEDULE;
    else if (r < 84) c.command = CMD_SET_STATE;
    else if (r < 97) c.command = CMD_QUERY;
    else c.command = 4'($urandom_range(15, 9));
    // mostly live ids so lookups hit
    if ($urandom_range(9) < 8) c.target_pid = id_next - 16'($urandom_range(20));
    else c.target_pid = 16'($urandom);
    return c;
  endfunction

  function automatic cmd_item_t mk(logic [3:0] op, logic [15:0] pid = 0,
                                   logic [2:0] pr = 0, logic [2:0] st = 0,
                                   logic [31:0] xv = 0);
    return '{op, pid, pr, st, xv};
  endfunction

  task automatic drain;
    while (pending_cmds.size() > 0 || start || awaited.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_slice(logic [15:0] v);
    cfg_owned = 1'b1;
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_SLICE; pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    slice_len = v;
    cfg_owned = 1'b0;
  endtask

  task automatic random_phase(int n, int pct);
    idle_pct = pct;
    repeat (n) pending_cmds.push_back(rand_cmd());
    drain();
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; in_command = '0; in_target_pid = '0;
    in_new_priority = '0; in_new_state = '0; in_exit_value = '0;
    idle_pct = 0; hold_off = 0; cfg_owned = 0; mismatches = 0; cycles = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 0; tbl_pid[i] = 0; tbl_state[i] = TS_CREATED; tbl_prio[i] = 0;
      tbl_time[i] = 0; tbl_born[i] = 0; tbl_parent[i] = 0; tbl_exit[i] = 0;
    end
    cur_slot = 0; live = 0; id_next = PID_FIRST; ticks = 0;
    slice_len = 16'(SLICE_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table cases, fill to overflow, protected kill, extremes
    pending_cmds.push_back(mk(CMD_TERMINATE));
    pending_cmds.push_back(mk(CMD_YIELD));
    pending_cmds.push_back(mk(CMD_SCHEDULE));
    pending_cmds.push_back(mk(CMD_QUERY, 16'd0));
    repeat (SLOTS + 1) pending_cmds.push_back(mk(CMD_CREATE, 16'hFFFF, 3'd7));
    drain();
    pending_cmds.push_back(mk(CMD_KILL, 16'd1));
    pending_cmds.push_back(mk(CMD_SCHEDULE));
    pending_cmds.push_back(mk(CMD_DESTROY, 16'd1));
    pending_cmds.push_back(mk(CMD_TERMINATE, 0, 0, 0, 32'h8000_0000));
    pending_cmds.push_back(mk(CMD_QUERY, 16'd1));
    pending_cmds.push_back(mk(CMD_SET_STATE, 16'd2, 0, 3'd7));
    pending_cmds.push_back(mk(CMD_SET_STATE, 16'd3, 0, TS_WAITING));
    pending_cmds.push_back(mk(CMD_TICK));
    pending_cmds.push_back(mk(4'd15, 16'hFFFF, 3'd7, 3'd7, 32'h7FFF_FFFF));
    drain();

    write_slice(16'd1);
    random_phase(150, 0);
    write_slice(16'd0);
    random_phase(100, 67);
    write_slice(16'hFFFF);
    random_phase(120, 17);
    write_slice(16'd3);
    random_phase(150, 67);
    // sender holds off until every answer is in, then resumes
    hold_off = 1'b1;
    random_phase(0, 0);
    hold_off = 1'b0;
    write_slice(16'd2);
    random_phase(180, 17);
    // many create/tick pairs to keep ids advancing
    write_slice(16'd5);
    idle_pct = 0;
    repeat (100) begin
      pending_cmds.push_back(mk(CMD_CREATE, 0, 3'($urandom_range(7))));
      pending_cmds.push_back(mk(CMD_TICK));
    end
    drain();

    if (mismatches == 0)
      $display("process_table_round_robin_scheduler_unit verification clean");
    else
      $display("process_table_round_robin_scheduler_unit verification failed");
    $finish;
  end

endmodule
